// ===== rtl/core/modular_inverse_ext_euclid_64_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the modular inverse block
// Implication checks, clocked and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EXT_EUCLID_64_TOP_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_64_TOP_ASSERT_SVH

// same-cycle implication
`define MIE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mie: same-cycle check failed");

// next-cycle implication
`define MIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mie: next-cycle check failed");

`endif

// ===== rtl/core/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// mie_pkg
// Types and constants shared by the modular inverse block.
// ----------------------------------------------------------------------------
package mie_pkg;

  // fixed width of the operand, modulus and inverse fields
  localparam int unsigned FIELD_BITS    = 63;
  // default datapath word width (coefficients are two's complement words)
  localparam int unsigned DEF_WORD_BITS = 64;

  // input transaction
  typedef struct packed {
    logic [FIELD_BITS-1:0] operand;
    logic [FIELD_BITS-1:0] modulus;
  } mie_in_t;

  // result transaction
  typedef struct packed {
    logic [FIELD_BITS-1:0] inverse;
    logic                  no_inverse;
  } mie_out_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture a new transaction
    logic div_init;  // seed the divider from the current remainders
    logic div_step;  // one restoring-division bit
    logic update;    // shift remainders and coefficients
    logic finish;    // form and register the result
  } mie_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic rem_lo_zero;  // Euclid loop has terminated
  } mie_stat_t;

endpackage

// ===== rtl/core/mie_ctrl.sv =====
// ----------------------------------------------------------------------------
// mie_ctrl
// Sequencer for the Euclid rounds: a check state, a bit-serial division
// of WORD_BITS-1 steps and an update state per round, then the result.
// ----------------------------------------------------------------------------
module mie_ctrl import mie_pkg::*; #(
  parameter int unsigned WORD_BITS = DEF_WORD_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output mie_cmd_t  cmd_o,
  input  mie_stat_t stat_i
);

  localparam int unsigned F_BITS = WORD_BITS - 1;
  localparam int unsigned CNT_W  = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(F_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_DIV    = 5'b00100,
    S_UPDATE = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.rem_lo_zero) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_CHECK;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== rtl/core/mie_dpath.sv =====
// ----------------------------------------------------------------------------
// mie_dpath
// Remainder and coefficient registers, a restoring divider that produces one
// quotient bit per step, and a shift-add accumulator that forms
// quotient * coefficient alongside the division.
// ----------------------------------------------------------------------------
module mie_dpath import mie_pkg::*; #(
  parameter int unsigned WORD_BITS = DEF_WORD_BITS
) (
  input  logic      clk_i,
  input  mie_cmd_t  cmd_i,
  output mie_stat_t stat_o,
  input  mie_in_t   op_i,
  output mie_out_t  res_o
);

  localparam int unsigned W = WORD_BITS;
  localparam int unsigned F = WORD_BITS - 1;

  logic [F-1:0] n_q;
  logic         nz_q;
  logic [F-1:0] rem_hi_q, rem_lo_q;
  logic [W-1:0] co_hi_q, co_lo_q;
  logic [F-1:0] par_q;   // partial remainder
  logic [F-1:0] dq_q;    // dividend bits out, quotient bits in
  logic [W-1:0] prod_q;  // quotient * co_lo, mod 2^W
  mie_out_t     res_q;

  logic [F:0]   sh;
  logic [F:0]   diff;
  logic         ge;
  logic [W-1:0] sum_n;
  logic [W-1:0] fixed;
  logic         none;

  // one restoring-division step
  assign sh   = {par_q, dq_q[F-1]};
  assign ge   = (sh >= {1'b0, rem_lo_q});
  assign diff = sh - {1'b0, rem_lo_q};

  // final correction into 0..n-1
  assign sum_n = co_hi_q + {1'b0, n_q};
  assign fixed = co_hi_q[W-1] ? sum_n : co_hi_q;
  assign none  = nz_q || (rem_hi_q[F-1:1] != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q      <= op_i.modulus[F-1:0];
      nz_q     <= (op_i.modulus[F-1:0] == '0);
      rem_hi_q <= op_i.modulus[F-1:0];
      rem_lo_q <= op_i.operand[F-1:0];
      co_hi_q  <= '0;
      co_lo_q  <= W'(1);
    end
    if (cmd_i.div_init) begin
      par_q  <= '0;
      dq_q   <= rem_hi_q;
      prod_q <= '0;
    end
    if (cmd_i.div_step) begin
      par_q  <= ge ? diff[F-1:0] : sh[F-1:0];
      dq_q   <= {dq_q[F-2:0], ge};
      prod_q <= {prod_q[W-2:0], 1'b0} + (ge ? co_lo_q : '0);
    end
    if (cmd_i.update) begin
      rem_hi_q <= rem_lo_q;
      rem_lo_q <= par_q;
      co_hi_q  <= co_lo_q;
      co_lo_q  <= co_hi_q - prod_q;
    end
    if (cmd_i.finish) begin
      res_q.no_inverse <= none;
      res_q.inverse    <= none ? '0 : FIELD_BITS'(fixed[F-1:0]);
    end
  end

  assign stat_o.rem_lo_zero = (rem_lo_q == '0);
  assign res_o              = res_q;

endmodule

// ===== rtl/core/modular_inverse_ext_euclid_64_top.sv =====
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_64_top
// Modular inverse by the extended Euclidean algorithm.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   input    | start, busy          | op_i  (operand, modulus)
//   result   | done_o (1-cycle)     | res_o (inverse, no_inverse)
//
// Each Euclid round is a check, WORD_BITS-1 steps of the bit-serial divider
// and a coefficient update. After acceptance the block loads the operands,
// runs R rounds (up to about 92 at 64 bits), a final check and a finish
// state, then shows the result strobe. One item is in flight at a time;
// busy is high after acceptance and falls in the cycle in which done_o is
// shown. Reset clears the controller only. The receiver cannot stall: it
// is to take the result in the done_o cycle only, unenforced by the block.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_64_top import mie_pkg::*; #(
  parameter int unsigned WORD_BITS = DEF_WORD_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  mie_in_t  op_i,
  output logic     done_o,
  output mie_out_t res_o
);

  mie_cmd_t  cmd;
  mie_stat_t stat;

  // sequencer
  mie_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  // arithmetic
  mie_dpath #(
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .op_i   (op_i),
    .res_o  (res_o)
  );

endmodule

// ===== rtl/core/mie_checker.sv =====
// ----------------------------------------------------------------------------
// mie_checker
// Port-level checks on the modular inverse block, bound to the top level.
// ----------------------------------------------------------------------------
`include "modular_inverse_ext_euclid_64_top_assert.svh"

module mie_checker import mie_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     done_o,
  input mie_out_t res_o
);

  // an accepted transaction keeps the block busy
  `MIE_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // busy only drops as the result is shown
  `MIE_ASSERT_SAME(a_fall_done, clk_i, rst_ni, $fell(busy), done_o)
  // a result only appears as busy drops
  `MIE_ASSERT_SAME(a_done_fall, clk_i, rst_ni, done_o, $fell(busy))
  // no inverse means a zero result value
  `MIE_ASSERT_SAME(a_none_zero, clk_i, rst_ni, done_o && res_o.no_inverse,
                   res_o.inverse == '0)

endmodule

bind modular_inverse_ext_euclid_64_top mie_checker u_mie_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
